@@ rtl/fpfa_pkg.sv @@
// ---------------------------------------------------------------------------
// fpfa_pkg - shared definitions for the fixed partition fit allocator
// Table geometry, command, fit and config codes, and the structs for command
// items, results and the commands from the sequencer to the partition store.
// ---------------------------------------------------------------------------
package fpfa_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int FREE_W     = 20;
    localparam int SUM_W      = FREE_W + 1;

    localparam int CMD_W      = 2;
    localparam int BIDX_W     = 4;
    localparam int AMT_W      = 16;
    localparam int BCNT_W     = 5;
    localparam int MODE_W     = 2;

    localparam logic [FREE_W-1:0] FREE_MAX = {FREE_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd2;

    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;
    localparam logic [MODE_W-1:0] FIT_NEXT  = 2'd3;

    localparam logic CFG_FIT_MODE    = 1'b0;
    localparam logic CFG_BLOCK_COUNT = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BIDX_W-1:0] block_index;
        logic [AMT_W-1:0]  amount_kb;
    } item_t;

    typedef struct packed {
        logic              granted;
        logic [BIDX_W-1:0] chosen_block;
        logic [FREE_W-1:0] free_total;
    } result_t;

    typedef struct packed {
        logic                 wr_en;
        logic [IDX_W-1:0]     wr_idx;
        logic [SIZE_BITS-1:0] wr_data;
        logic                 set_en;
        logic [IDX_W-1:0]     set_idx;
        logic                 clr_all;
        logic [IDX_W-1:0]     rd_idx;
    } store_cmd_t;

endpackage

@@ rtl/fixed_partition_fit_allocator.sv @@
// ---------------------------------------------------------------------------
// fixed_partition_fit_allocator - fixed partition allocator top level
// Load, clear and allocate commands over a 16-entry partition table with
// first, best, worst and next fit search.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one command beat: command, block_index and amount_kb.
//   m_axis returns one result beat per command: granted, chosen_block and
//   the free total left after the command.
//   cfg_wr_en writes fit_mode (index 0) or block_count (index 1); write only
//   while no command is in flight.
//   A load is written to the table as the command is accepted; a clear sums
//   one table entry per cycle; an allocation compares one entry per cycle
//   over at most n entries, n being the active partition count, then passes
//   a commit state when a partition is granted. The result waits in the done
//   state until the output register is free. s_axis_tready is high only
//   while the sequencer is idle; one command is worked on at a time.
//   A stalled m_axis holds its beat; the sequencer takes the next command
//   and parks its result until the output register frees.
//   Reset frees all partitions, zeroes the free total and next-fit pointer,
//   selects first fit and 16 partitions. Sizes are undefined until loaded.
// ---------------------------------------------------------------------------
module fixed_partition_fit_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // command[1:0], block_index[5:2], amount_kb[21:6]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // granted[0], chosen_block[4:1], free_total[24:5]
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_index,
    input  logic [4:0]  cfg_wr_data
);

    logic [fpfa_pkg::MODE_W-1:0] fit_mode_reg;
    logic [fpfa_pkg::BCNT_W-1:0] block_count_reg;
    logic                        m_valid_reg;
    fpfa_pkg::result_t           m_data_reg;

    fpfa_pkg::item_t             in_item;
    fpfa_pkg::result_t           res;
    logic                        res_valid;
    logic                        out_free;
    fpfa_pkg::store_cmd_t        store_cmd;
    logic [fpfa_pkg::SIZE_BITS-1:0] rd_size;
    logic                        rd_occupied;

    assign in_item.command     = s_axis_tdata[1:0];
    assign in_item.block_index = s_axis_tdata[5:2];
    assign in_item.amount_kb   = s_axis_tdata[21:6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg    <= fpfa_pkg::FIT_FIRST;
            block_count_reg <= fpfa_pkg::BCNT_W'(fpfa_pkg::MAX_BLOCKS);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                fpfa_pkg::CFG_FIT_MODE:    fit_mode_reg    <= cfg_wr_data[1:0];
                fpfa_pkg::CFG_BLOCK_COUNT: block_count_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    fpfa_store u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (store_cmd),
        .rd_size     (rd_size),
        .rd_occupied (rd_occupied)
    );

    fpfa_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_item     (in_item),
        .in_ready    (s_axis_tready),
        .fit_mode    (fit_mode_reg),
        .block_count (block_count_reg),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .store_cmd   (store_cmd),
        .rd_size     (rd_size),
        .rd_occupied (rd_occupied)
    );

    // output register: load a new beat when empty or being drained
    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_data_reg.free_total, m_data_reg.chosen_block,
                            m_data_reg.granted};

endmodule

@@ rtl/fpfa_store.sv @@
// ---------------------------------------------------------------------------
// fpfa_store - partition size table and occupancy flags
// One write port for sizes, a set and clear-all port for the flags, and one
// registered read port that the sequencer addresses with its next scan position.
// ---------------------------------------------------------------------------
module fpfa_store (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  fpfa_pkg::store_cmd_t           cmd,
    output logic [fpfa_pkg::SIZE_BITS-1:0] rd_size,
    output logic                           rd_occupied
);

    logic [fpfa_pkg::SIZE_BITS-1:0] size_mem [fpfa_pkg::MAX_BLOCKS];
    logic [fpfa_pkg::MAX_BLOCKS-1:0] occ_reg;
    logic [fpfa_pkg::MAX_BLOCKS-1:0] occ_next;
    logic [fpfa_pkg::SIZE_BITS-1:0] rd_size_reg;
    logic                           rd_occ_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            size_mem[cmd.wr_idx] <= cmd.wr_data;
        end
        rd_size_reg <= size_mem[cmd.rd_idx];
    end

    always_comb begin
        occ_next = occ_reg;
        if (cmd.clr_all) begin
            occ_next = '0;
        end else if (cmd.set_en) begin
            occ_next[cmd.set_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_occ_reg <= occ_reg[cmd.rd_idx];
    end

    assign rd_size     = rd_size_reg;
    assign rd_occupied = rd_occ_reg;

endmodule

@@ rtl/fpfa_seq.sv @@
// ---------------------------------------------------------------------------
// fpfa_seq - command sequencer with one shared compare and add unit
// Walks the partition table one entry per cycle: sums sizes for a clear,
// searches for a fitting free partition for an allocation.
// ---------------------------------------------------------------------------
module fpfa_seq (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    input  fpfa_pkg::item_t                in_item,
    output logic                           in_ready,
    input  logic [fpfa_pkg::MODE_W-1:0]    fit_mode,
    input  logic [fpfa_pkg::BCNT_W-1:0]    block_count,
    input  logic                           out_free,
    output logic                           res_valid,
    output fpfa_pkg::result_t              res,
    output fpfa_pkg::store_cmd_t           store_cmd,
    input  logic [fpfa_pkg::SIZE_BITS-1:0] rd_size,
    input  logic                           rd_occupied
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    localparam int IW = fpfa_pkg::IDX_W;
    localparam int CW = fpfa_pkg::CNT_W;
    localparam int SW = fpfa_pkg::SIZE_BITS;
    localparam int FW = fpfa_pkg::FREE_W;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] ptr_reg, ptr_next;
    logic [FW-1:0] free_reg, free_next;
    logic [FW-1:0] acc_reg, acc_next;
    logic          found_reg, found_next;
    logic [IW-1:0] sel_reg, sel_next;
    logic [SW-1:0] best_reg, best_next;
    logic          clear_reg, clear_next;
    logic [SW-1:0] req_reg, req_next;
    logic          granted_reg, granted_next;

    logic [CW-1:0] n_eff;
    logic [CW-1:0] ptr_ext;
    logic [IW-1:0] pos_wrap;
    logic [IW-1:0] sel_wrap;
    logic          last_step;
    logic          qual;
    logic          better;
    logic [fpfa_pkg::SUM_W-1:0] acc_sum;
    logic          accept;

    // effective partition count: zero acts as one, clamp to the table depth
    always_comb begin
        if (block_count == '0) begin
            n_eff = CW'(1);
        end else if (CW'(block_count) > CW'(fpfa_pkg::MAX_BLOCKS)) begin
            n_eff = CW'(fpfa_pkg::MAX_BLOCKS);
        end else begin
            n_eff = CW'(block_count);
        end
    end

    assign ptr_ext   = CW'(ptr_reg);
    assign pos_wrap  = (CW'(pos_reg) + CW'(1) == n_eff) ? '0 : pos_reg + IW'(1);
    assign sel_wrap  = (CW'(sel_reg) + CW'(1) == n_eff) ? '0 : sel_reg + IW'(1);
    assign last_step = (cnt_reg + CW'(1) == n_eff);

    // shared compare and add unit
    assign qual    = !rd_occupied && (rd_size >= req_reg);
    assign better  = (fit_mode == fpfa_pkg::FIT_BEST)  ? (rd_size < best_reg) :
                     (fit_mode == fpfa_pkg::FIT_WORST) ? (rd_size > best_reg) : 1'b0;
    assign acc_sum = fpfa_pkg::SUM_W'(acc_reg) + fpfa_pkg::SUM_W'(rd_size);

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == ST_DONE);

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        ptr_next     = ptr_reg;
        free_next    = free_reg;
        acc_next     = acc_reg;
        found_next   = found_reg;
        sel_next     = sel_reg;
        best_next    = best_reg;
        clear_next   = clear_reg;
        req_next     = req_reg;
        granted_next = granted_reg;

        store_cmd         = '0;
        store_cmd.set_idx = sel_reg;
        store_cmd.wr_idx  = IW'(in_item.block_index);
        store_cmd.wr_data = SW'(in_item.amount_kb);

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    granted_next = 1'b0;
                    sel_next     = '0;
                    found_next   = 1'b0;
                    cnt_next     = '0;
                    acc_next     = '0;
                    req_next     = SW'(in_item.amount_kb);
                    priority if (in_item.command == fpfa_pkg::CMD_LOAD) begin
                        store_cmd.wr_en = (32'(in_item.block_index) < fpfa_pkg::MAX_BLOCKS);
                        state_next      = ST_DONE;
                    end else if (in_item.command == fpfa_pkg::CMD_CLEAR) begin
                        store_cmd.clr_all = 1'b1;
                        ptr_next          = '0;
                        clear_next        = 1'b1;
                        pos_next          = '0;
                        state_next        = ST_SCAN;
                    end else if (in_item.command == fpfa_pkg::CMD_ALLOC) begin
                        clear_next = 1'b0;
                        // next fit starts at the pointer unless it is stale
                        if (fit_mode == fpfa_pkg::FIT_NEXT && ptr_ext < n_eff) begin
                            pos_next = ptr_reg;
                        end else begin
                            pos_next = '0;
                        end
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + CW'(1);
                pos_next = pos_wrap;
                if (clear_reg) begin
                    acc_next = (acc_sum > fpfa_pkg::SUM_W'(fpfa_pkg::FREE_MAX)) ?
                               fpfa_pkg::FREE_MAX : FW'(acc_sum);
                    if (last_step) begin
                        free_next  = acc_next;
                        state_next = ST_DONE;
                    end
                end else if (fit_mode == fpfa_pkg::FIT_FIRST ||
                             fit_mode == fpfa_pkg::FIT_NEXT) begin
                    if (qual) begin
                        sel_next   = pos_reg;
                        best_next  = rd_size;
                        state_next = ST_COMMIT;
                    end else if (last_step) begin
                        state_next = ST_DONE;
                    end
                end else begin
                    if (qual && (!found_reg || better)) begin
                        found_next = 1'b1;
                        sel_next   = pos_reg;
                        best_next  = rd_size;
                    end
                    if (last_step) begin
                        state_next = (found_next) ? ST_COMMIT : ST_DONE;
                    end
                end
            end
            ST_COMMIT: begin
                store_cmd.set_en = 1'b1;
                granted_next     = 1'b1;
                free_next = (FW'(best_reg) >= free_reg) ? '0 : free_reg - FW'(best_reg);
                if (fit_mode == fpfa_pkg::FIT_NEXT) begin
                    ptr_next = sel_wrap;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register can take the beat
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // store read data is registered: address the entry scanned next cycle
        store_cmd.rd_idx = pos_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ptr_reg     <= '0;
            free_reg    <= '0;
            found_reg   <= 1'b0;
            clear_reg   <= 1'b0;
            granted_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            free_reg    <= free_next;
            found_reg   <= found_next;
            clear_reg   <= clear_next;
            granted_reg <= granted_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        acc_reg  <= acc_next;
        sel_reg  <= sel_next;
        best_reg <= best_next;
        req_reg  <= req_next;
    end

    assign res.granted      = granted_reg;
    assign res.chosen_block = (granted_reg) ? fpfa_pkg::BIDX_W'(sel_reg) : '0;
    assign res.free_total   = free_reg;

endmodule
